FILE: rtl/bpfa_pkg.sv
package bpfa_pkg;

  localparam int unsigned FRAMES     = 4096;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned FRAME_W    = $clog2(FRAMES);
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BIT_W      = $clog2(WORD_W);
  localparam int unsigned ROWS       = FRAMES / WORD_W;
  localparam int unsigned ROW_W      = $clog2(ROWS);
  localparam int unsigned LEN_W      = FRAME_W + 1;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_FREE  = 2'd2,
    FUNC_QUERY = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    RD_HINT,
    RD_PAGE,
    RD_SCAN,
    RD_MARK,
    RD_RESC
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_SET_HINT,
    WR_MARK,
    WR_CLEAR
  } wr_sel_e;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    alloc_apply;
    logic    scan_step;
    logic    mark_init;
    logic    mark_next;
    logic    resc_init;
    logic    resc_step;
    logic    free_apply;
    logic    query_cap;
    logic    result;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  hint_none;
    logic  kern_ok;
    logic  scan_hit;
    logic  scan_fail;
    logic  word_end;
    logic  run_zero;
    logic  mark_last;
    logic  resc_done;
    logic  out_busy;
  } sts_t;

endpackage

FILE: rtl/bpfa_ram.sv
module bpfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bpfa_datapath.sv
module bpfa_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]      cfg_wdata_i,
  input  logic [bpfa_pkg::IN_DATA_W-1:0]   in_data_i,
  input  logic [bpfa_pkg::FUNC_W-1:0]      in_func_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bpfa_pkg::OUT_DATA_W-1:0]  out_data_o,
  input  bpfa_pkg::cmd_t                   cmd_i,
  output bpfa_pkg::sts_t                   sts_o
);

  localparam int unsigned FW = bpfa_pkg::FRAME_W;
  localparam int unsigned LW = bpfa_pkg::LEN_W;
  localparam int unsigned BW = bpfa_pkg::BIT_W;
  localparam int unsigned RW = bpfa_pkg::ROW_W;
  localparam int unsigned WW = bpfa_pkg::WORD_W;
  localparam int unsigned CW = bpfa_pkg::CNT_W;

  bpfa_pkg::func_e       func_q;
  logic [FW-1:0]         page_q;
  logic [LW-1:0]         align_q, run_q;
  logic [bpfa_pkg::ADDR_W-1:0] kern_q;
  logic [FW-1:0]         hint_q;
  logic                  hint_none_q;
  logic [CW-1:0]         cnt_q;
  logic [FW:0]           f_q;
  logic [FW+1:0]         na_q;
  logic [LW-1:0]         c_q;
  logic [FW-1:0]         s_q;
  logic [RW-1:0]         mw_q, rw_q;
  logic [bpfa_pkg::ROWS-1:0] valid_q;
  logic                  rvld_q;
  logic                  ok_q, fstate_q;
  logic [FW-1:0]         pout_q;
  logic                  out_valid_q;
  logic [bpfa_pkg::OUT_DATA_W-1:0] out_data_q;

  logic [WW-1:0] ram_rdata, rword, wdata, mask, lo_mask, hi_mask;
  logic [RW-1:0] raddr, waddr;
  logic [FW-1:0] e_frame;
  logic [RW-1:0] s_row, e_row;
  logic [BW-1:0] lo, hi, zidx;
  logic          zfound;
  logic          b, aligned, scan_hit;
  logic [LW-1:0] c_inc, c_d;
  logic [FW-1:0] hit_start;
  logic [bpfa_pkg::ADDR_W-1:0] page_addr;
  logic [LW-1:0] align_in;

  assign rword = rvld_q ? ram_rdata : '0;

  // run geometry
  assign e_frame = FW'(s_q + run_q[FW-1:0] - 1'b1);
  assign s_row   = s_q[FW-1:BW];
  assign e_row   = e_frame[FW-1:BW];
  assign lo      = (mw_q == s_row) ? s_q[BW-1:0] : '0;
  assign hi      = (mw_q == e_row) ? e_frame[BW-1:0] : '1;
  assign lo_mask = {WW{1'b1}} << lo;
  assign hi_mask = {WW{1'b1}} >> (BW'(WW - 1) - hi);
  assign mask    = lo_mask & hi_mask;

  // scan step on one frame
  assign b       = rword[f_q[BW-1:0]];
  assign aligned = ({1'b0, f_q} == na_q);
  assign c_inc   = c_q + 1'b1;

  always_comb begin
    c_d       = c_q;
    scan_hit  = 1'b0;
    hit_start = s_q;
    if (c_q == '0) begin
      hit_start = f_q[FW-1:0];
      if (aligned && !b) begin
        c_d      = LW'(1);
        scan_hit = (run_q <= LW'(1));
      end
    end else if (!b) begin
      c_d      = c_inc;
      scan_hit = (c_inc == run_q);
    end else begin
      c_d = '0;
    end
  end

  // lowest free bit in a word
  always_comb begin
    zidx = '0;
    for (int i = WW - 1; i >= 0; i--) begin
      if (!rword[i]) begin
        zidx = BW'(i);
      end
    end
  end
  assign zfound = ~&rword;

  assign page_addr = bpfa_pkg::ADDR_W'({page_q, {bpfa_pkg::PAGE_SHIFT{1'b0}}});
  assign align_in  = (in_data_i[2*FW:FW] == '0) ? LW'(1) : in_data_i[2*FW:FW];

  always_comb begin
    case (cmd_i.rd_sel)
      bpfa_pkg::RD_HINT: raddr = hint_q[FW-1:BW];
      bpfa_pkg::RD_PAGE: raddr = page_q[FW-1:BW];
      bpfa_pkg::RD_SCAN: raddr = f_q[FW-1:BW];
      bpfa_pkg::RD_MARK: raddr = mw_q;
      bpfa_pkg::RD_RESC: raddr = rw_q;
      default:           raddr = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      bpfa_pkg::WR_SET_HINT: begin
        waddr = hint_q[FW-1:BW];
        wdata = rword | (WW'(1) << hint_q[BW-1:0]);
      end
      bpfa_pkg::WR_MARK: begin
        waddr = mw_q;
        wdata = rword | mask;
      end
      bpfa_pkg::WR_CLEAR: begin
        waddr = page_q[FW-1:BW];
        wdata = rword & ~(WW'(1) << page_q[BW-1:0]);
      end
      default: begin
        waddr = '0;
        wdata = rword;
      end
    endcase
  end

  bpfa_ram #(
    .WIDTH(WW),
    .DEPTH(bpfa_pkg::ROWS)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q      <= '0;
      hint_q      <= '0;
      hint_none_q <= 1'b0;
      cnt_q       <= '0;
      valid_q     <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        kern_q <= cfg_wdata_i;
      end
      if (cmd_i.rd_en) begin
        rvld_q <= valid_q[raddr];
      end
      if (cmd_i.wr_en) begin
        valid_q[waddr] <= 1'b1;
      end
      if (cmd_i.alloc_apply && cnt_q != bpfa_pkg::CNT_MAX) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.free_apply) begin
        if (hint_none_q || page_q < hint_q) begin
          hint_q      <= page_q;
          hint_none_q <= 1'b0;
        end
        if (rword[page_q[BW-1:0]] && cnt_q != '0) begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
      if (cmd_i.resc_step) begin
        if (zfound) begin
          hint_q      <= {rw_q, zidx};
          hint_none_q <= 1'b0;
        end else if (rw_q == RW'(bpfa_pkg::ROWS - 1)) begin
          hint_q      <= '0;
          hint_none_q <= 1'b1;
        end
      end
      if (cmd_i.result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= bpfa_pkg::func_e'(in_func_i);
      page_q   <= in_data_i[FW-1:0];
      align_q  <= align_in;
      run_q    <= in_data_i[FW+2*LW-1:FW+LW];
      ok_q     <= 1'b0;
      pout_q   <= '0;
      fstate_q <= 1'b0;
      f_q      <= '0;
      na_q     <= '0;
      c_q      <= '0;
    end
    if (cmd_i.alloc_apply) begin
      ok_q   <= 1'b1;
      pout_q <= hint_q;
    end
    if (cmd_i.scan_step) begin
      c_q <= c_d;
      f_q <= f_q + 1'b1;
      if (c_q == '0) begin
        s_q <= f_q[FW-1:0];
      end
      if (aligned) begin
        na_q <= na_q + (FW+2)'(align_q);
      end
      if (scan_hit) begin
        ok_q   <= 1'b1;
        pout_q <= hit_start;
      end
    end
    if (cmd_i.mark_init) begin
      mw_q <= hit_start[FW-1:BW];
    end else if (cmd_i.mark_next) begin
      mw_q <= mw_q + 1'b1;
    end
    if (cmd_i.resc_init) begin
      rw_q <= hint_q[FW-1:BW];
    end else if (cmd_i.resc_step) begin
      rw_q <= rw_q + 1'b1;
    end
    if (cmd_i.free_apply) begin
      ok_q <= rword[page_q[BW-1:0]];
    end
    if (cmd_i.query_cap) begin
      fstate_q <= rword[page_q[BW-1:0]];
    end
    if (cmd_i.result) begin
      out_data_q <= bpfa_pkg::OUT_DATA_W'({cnt_q, fstate_q, pout_q, ok_q});
    end
  end

  assign sts_o.func      = func_q;
  assign sts_o.hint_none = hint_none_q;
  assign sts_o.kern_ok   = page_addr > kern_q;
  assign sts_o.scan_hit  = scan_hit;
  assign sts_o.scan_fail = !scan_hit && (f_q == (FW+1)'(bpfa_pkg::FRAMES - 1));
  assign sts_o.word_end  = &f_q[BW-1:0];
  assign sts_o.run_zero  = (run_q == '0);
  assign sts_o.mark_last = (mw_q == e_row);
  assign sts_o.resc_done = zfound || (rw_q == RW'(bpfa_pkg::ROWS - 1));
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/bpfa_ctrl.sv
module bpfa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bpfa_pkg::sts_t sts_i,
  output bpfa_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A1_RD,
    ST_A1_WR,
    ST_RS_RD,
    ST_RS_BIT,
    ST_MK_RD,
    ST_MK_WR,
    ST_RESC_RD,
    ST_RESC_CHK,
    ST_FR_RD,
    ST_FR_WR,
    ST_Q_RD,
    ST_Q_CAP,
    ST_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_A1_RD;
        end
      end
      ST_A1_RD: begin
        case (sts_i.func)
          bpfa_pkg::FUNC_ALLOC: begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = bpfa_pkg::RD_HINT;
            state_d      = sts_i.hint_none ? ST_FIN : ST_A1_WR;
          end
          bpfa_pkg::FUNC_RUN:   state_d = ST_RS_RD;
          bpfa_pkg::FUNC_FREE:  state_d = ST_FR_RD;
          bpfa_pkg::FUNC_QUERY: state_d = ST_Q_RD;
          default:              state_d = ST_FIN;
        endcase
      end
      ST_A1_WR: begin
        cmd_o.wr_en       = 1'b1;
        cmd_o.wr_sel      = bpfa_pkg::WR_SET_HINT;
        cmd_o.alloc_apply = 1'b1;
        state_d           = ST_RESC_RD;
      end
      ST_RS_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = bpfa_pkg::RD_SCAN;
        state_d      = ST_RS_BIT;
      end
      ST_RS_BIT: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_hit) begin
          cmd_o.mark_init = 1'b1;
          state_d         = sts_i.run_zero ? ST_FIN : ST_MK_RD;
        end else if (sts_i.scan_fail) begin
          state_d = ST_FIN;
        end else if (sts_i.word_end) begin
          state_d = ST_RS_RD;
        end
      end
      ST_MK_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = bpfa_pkg::RD_MARK;
        state_d      = ST_MK_WR;
      end
      ST_MK_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = bpfa_pkg::WR_MARK;
        if (sts_i.mark_last) begin
          state_d = ST_RESC_RD;
        end else begin
          cmd_o.mark_next = 1'b1;
          state_d         = ST_MK_RD;
        end
      end
      ST_RESC_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = bpfa_pkg::RD_RESC;
        state_d      = ST_RESC_CHK;
      end
      ST_RESC_CHK: begin
        cmd_o.resc_step = 1'b1;
        state_d         = sts_i.resc_done ? ST_FIN : ST_RESC_RD;
      end
      ST_FR_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = bpfa_pkg::RD_PAGE;
        state_d      = sts_i.kern_ok ? ST_FR_WR : ST_FIN;
      end
      ST_FR_WR: begin
        cmd_o.wr_en      = 1'b1;
        cmd_o.wr_sel     = bpfa_pkg::WR_CLEAR;
        cmd_o.free_apply = 1'b1;
        state_d          = ST_FIN;
      end
      ST_Q_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = bpfa_pkg::RD_PAGE;
        state_d      = ST_Q_CAP;
      end
      ST_Q_CAP: begin
        cmd_o.query_cap = 1'b1;
        state_d         = ST_FIN;
      end
      ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.result = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // rescan always starts from the hint row
    if ((state_q == ST_A1_WR) || (state_q == ST_MK_WR && sts_i.mark_last)) begin
      cmd_o.resc_init = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

FILE: rtl/bitmap_page_frame_allocator_core.sv
// channel   | ports                          | beat contents
// ----------+--------------------------------+---------------------------------------------
// request   | s_axis_tvalid/tready/tdata/tuser | tuser func, tdata page, align, run_length
// result    | m_axis_tvalid/tready/tdata     | ok, page_out, frame_state, allocated_count
// config    | cfg_we_i/cfg_wdata_i           | kernel_end_address
//
// one request at a time; alloc one takes the hint frame, then a hint rescan visits bitmap
// rows from the hint row onward (32 frames a row, 128 rows)
// run allocation walks the bitmap one frame a cycle plus one read per row, then on a hit
// marks the rows of the run, each with a read and a write, and does the rescan
// reset empties the bitmap at once through per-row valid flags, no clearing pass
// a finished result waits in the output register while m_axis_tready is low
module bitmap_page_frame_allocator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]     cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bpfa_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // page, align, run_length
  input  logic [bpfa_pkg::FUNC_W-1:0]     s_axis_tuser,   // func
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bpfa_pkg::OUT_DATA_W-1:0] m_axis_tdata    // ok, page_out, frame_state, allocated_count
);

  bpfa_pkg::cmd_t cmd;
  bpfa_pkg::sts_t sts;

  bpfa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bpfa_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (s_axis_tdata),
    .in_func_i  (s_axis_tuser),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

FILE: tb/bitmap_page_frame_allocator_core_tb.sv
module bitmap_page_frame_allocator_core_tb;
  import bpfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    func_e       func;
    logic [11:0] page;
    logic [12:0] align;
    logic [12:0] run_len;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] page_out;
    logic        frame_state;
    logic [12:0] alloc_cnt;
  } res_t;

  localparam longint unsigned CYCLE_LIMIT = 64'd20_000_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [ADDR_W-1:0]     cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // page, align, run_length
  logic [FUNC_W-1:0]     s_axis_tuser = '0;  // func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;  // ok, page_out, frame_state, allocated_count

  bitmap_page_frame_allocator_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // allocator mirror
  logic        frame_map [FRAMES];
  logic [12:0] free_hint;
  logic        map_full;
  logic [12:0] single_cnt;
  logic [31:0] kernel_end;

  req_t   pending_reqs[$];
  res_t   expected_res[$];
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     n_errors = 0;
  int     n_results = 0;
  longint unsigned cycles = 0;

  function automatic logic frame_bit(int unsigned f);
    if (f >= FRAMES) return 1'b0;
    return frame_map[f];
  endfunction

  function automatic void find_hint();
    for (int f = 0; f < FRAMES; f++) begin
      if (!frame_map[f]) begin
        free_hint = 13'(f);
        map_full = 1'b0;
        return;
      end
    end
    free_hint = '0;
    map_full = 1'b1;
  endfunction

  function automatic logic claim_frame(int unsigned f);
    if (f >= FRAMES || frame_map[f]) return 1'b0;
    frame_map[f] = 1'b1;
    if (!map_full && f == free_hint) find_hint();
    return 1'b1;
  endfunction

  function automatic res_t allocator_result(req_t r);
    res_t        o;
    int unsigned stride;
    logic        fit;
    logic        was;
    logic [43:0] byte_addr;
    o = '0;
    case (r.func)
      FUNC_ALLOC: begin
        if (!map_full) begin
          o.page_out = free_hint[11:0];
          o.ok = 1'b1;
          if (claim_frame(32'(free_hint)) && single_cnt < CNT_MAX) single_cnt++;
        end
      end
      FUNC_RUN: begin
        stride = (r.align == '0) ? 32'd1 : 32'(r.align);
        for (int unsigned pg = 0; pg < FRAMES; pg += stride) begin
          if (frame_bit(pg)) continue;
          if (pg + r.run_len > FRAMES) continue;
          fit = 1'b1;
          for (int unsigned k = 1; k < r.run_len; k++) begin
            if (frame_bit(pg + k)) begin
              fit = 1'b0;
              break;
            end
          end
          if (fit) begin
            for (int unsigned k = 0; k < r.run_len; k++) void'(claim_frame(pg + k));
            o.ok = 1'b1;
            o.page_out = pg[11:0];
            break;
          end
        end
      end
      FUNC_FREE: begin
        byte_addr = {32'd0, r.page} << PAGE_SHIFT;
        if (byte_addr > {12'd0, kernel_end}) begin
          was = frame_map[r.page];
          if (map_full || r.page < free_hint) begin
            free_hint = {1'b0, r.page};
            map_full = 1'b0;
          end
          frame_map[r.page] = 1'b0;
          if (was) begin
            o.ok = 1'b1;
            if (single_cnt > 0) single_cnt--;
          end
        end
      end
      default: o.frame_state = frame_map[r.page];
    endcase
    o.alloc_cnt = single_cnt;
    return o;
  endfunction

  // driver
  always @(posedge clk_i) begin
    req_t r;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_axis_tvalid) expected_res.push_back(allocator_result(
            req_t'({func_e'(s_axis_tuser), s_axis_tdata[11:0], s_axis_tdata[24:12],
                    s_axis_tdata[37:25]})));
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          r = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= r.func;
          s_axis_tdata  <= {2'b00, r.run_len, r.align, r.page};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[0], m_axis_tdata[12:1], m_axis_tdata[13], m_axis_tdata[26:14]};
      if (expected_res.size() == 0) begin
        $error("result beat with nothing expected: %h", m_axis_tdata);
        n_errors++;
      end else begin
        want = expected_res.pop_front();
        n_results++;
        if (got.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, got.ok);
          n_errors++;
        end
        if (got.page_out !== want.page_out) begin
          $error("page_out: expected %0d, got %0d", want.page_out, got.page_out);
          n_errors++;
        end
        if (got.frame_state !== want.frame_state) begin
          $error("frame_state: expected %0d, got %0d", want.frame_state, got.frame_state);
          n_errors++;
        end
        if (got.alloc_cnt !== want.alloc_cnt) begin
          $error("allocated_count: expected %0d, got %0d", want.alloc_cnt, got.alloc_cnt);
          n_errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic req_t mk(func_e f, int pg, int al, int rl);
    req_t r;
    r.func = f;
    r.page = 12'(pg);
    r.align = 13'(al);
    r.run_len = 13'(rl);
    return r;
  endfunction

  function automatic req_t rand_req();
    int    sel;
    req_t  r;
    sel = $urandom_range(99);
    r = mk(FUNC_QUERY, int'($urandom_range(4095)), int'($urandom_range(8191)),
           int'($urandom_range(8191)));
    if (sel < 35) r.func = FUNC_ALLOC;
    else if (sel < 45) begin
      r.func = FUNC_RUN;
      r.align = 13'(($urandom_range(9) == 0) ? $urandom_range(8191) : (1 << $urandom_range(6)));
      r.run_len = 13'(($urandom_range(19) == 0) ? $urandom_range(8191) : $urandom_range(0, 40));
    end else if (sel < 75) begin
      r.func = FUNC_FREE;
      if ($urandom_range(3) != 0) r.page = 12'($urandom_range(300));
    end else if ($urandom_range(1)) r.page = 12'($urandom_range(300));
    return r;
  endfunction

  task automatic drain();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_res.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_kernel_end(logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    kernel_end = v;
  endtask

  task automatic run_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req());
    drain();
  endtask

  initial begin
    foreach (frame_map[i]) frame_map[i] = 1'b0;
    free_hint = '0;
    map_full = 1'b0;
    single_cnt = '0;
    kernel_end = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_kernel_end(32'h0000_1fff);
    pending_reqs.push_back(mk(FUNC_QUERY, 0, 0, 1));
    pending_reqs.push_back(mk(FUNC_ALLOC, 0, 0, 1));
    pending_reqs.push_back(mk(FUNC_ALLOC, 0, 0, 1));
    pending_reqs.push_back(mk(FUNC_FREE, 1, 0, 1));
    pending_reqs.push_back(mk(FUNC_FREE, 2, 0, 1));
    pending_reqs.push_back(mk(FUNC_FREE, 5, 0, 1));
    pending_reqs.push_back(mk(FUNC_RUN, 0, 0, 0));
    pending_reqs.push_back(mk(FUNC_RUN, 0, 4096, 3));
    pending_reqs.push_back(mk(FUNC_RUN, 0, 8, 5));
    pending_reqs.push_back(mk(FUNC_RUN, 0, 4095, 2));
    pending_reqs.push_back(mk(FUNC_RUN, 0, 1, 8191));
    pending_reqs.push_back(mk(FUNC_QUERY, 4095, 8191, 8191));
    pending_reqs.push_back(mk(FUNC_QUERY, 8, 0, 1));
    pending_reqs.push_back(mk(FUNC_FREE, 4095, 0, 1));
    pending_reqs.push_back(mk(FUNC_RUN, 0, 1, 4096));
    drain();

    write_kernel_end(32'h0);
    pending_reqs.push_back(mk(FUNC_FREE, 0, 0, 1));
    pending_reqs.push_back(mk(FUNC_RUN, 0, 2, 4096));
    pending_reqs.push_back(mk(FUNC_RUN, 0, 1, 4096));
    pending_reqs.push_back(mk(FUNC_ALLOC, 0, 0, 1));
    pending_reqs.push_back(mk(FUNC_FREE, 4095, 0, 1));
    pending_reqs.push_back(mk(FUNC_ALLOC, 0, 0, 1));
    pending_reqs.push_back(mk(FUNC_ALLOC, 0, 0, 1));
    pending_reqs.push_back(mk(FUNC_FREE, 4094, 0, 1));
    pending_reqs.push_back(mk(FUNC_RUN, 0, 0, 1));
    drain();
    for (int f = 1; f < 128; f++) pending_reqs.push_back(mk(FUNC_FREE, f, 0, 1));
    drain();

    run_phase(130, 0, 0);
    write_kernel_end(32'hffff_ffff);
    run_phase(130, 54, 0);
    write_kernel_end($urandom_range(32'h0004_0000));
    run_phase(130, 0, 54);
    write_kernel_end(32'h0000_0fff);
    run_phase(130, 9, 9);
    write_kernel_end($urandom);
    run_phase(130, 0, 0);
    repeat (50) @(posedge clk_i);

    $display("covered %0d result beats: directed corner cases, a low-frame free sweep and",
             n_results);
    $display("random alloc, run, free and query traffic under four idle settings");
    if (n_errors == 0 && expected_res.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/bpfa_pkg.sv
rtl/bpfa_ram.sv
rtl/bpfa_datapath.sv
rtl/bpfa_ctrl.sv
rtl/bitmap_page_frame_allocator_core.sv
tb/bitmap_page_frame_allocator_core_tb.sv
